>>> rtl/bsf3_pkg.sv
// ----------------------------------------------------------------------------
// bsf3_pkg
// Types, jump conditions and the control store of the box-sum tree sequencer.
// ----------------------------------------------------------------------------
package bsf3_pkg;

  typedef logic [4:0] pc_t;

  // jump conditions: the jump is taken when the selected condition holds
  typedef enum logic [3:0] {
    C_NEVER     = 4'd0,
    C_ALWAYS    = 4'd1,
    C_NO_REQ    = 4'd2,
    C_IS_ADD    = 4'd3,
    C_EMPTY     = 4'd4,
    C_TERM_SKIP = 4'd5,
    C_K_MORE    = 4'd6,
    C_J_MORE    = 4'd7,
    C_I_MORE    = 4'd8,
    C_TERM_MORE = 4'd9,
    C_OUT_FULL  = 4'd10,
    C_OUT_RANGE = 4'd11,
    C_CLR_MORE  = 4'd12
  } cond_e;

  typedef struct packed {
    logic  rdy;        // input request taken in this step
    logic  clr;        // clearing pass write
    logic  clr_acc;
    logic  term_rst;
    logic  ld_i;
    logic  ld_j;
    logic  ld_k;
    logic  rd;         // read tree cell at {i,j,k}
    logic  acc;        // add or subtract read data into the sum
    logic  wr;         // write read data plus amount back
    logic  step_i;
    logic  step_j;
    logic  step_k;
    logic  next_term;
    logic  emit;
    cond_e cond;
    pc_t   target;
  } ctrl_t;

  typedef struct packed {
    logic req;
    logic is_add;
    logic empty;
    logic term_skip;
    logic k_more;
    logic j_more;
    logic i_more;
    logic term_more;
    logic out_full;
    logic out_range;
    logic clr_more;
  } flags_t;

  localparam pc_t P_CLR   = 5'd0;
  localparam pc_t P_IDLE  = 5'd1;
  localparam pc_t P_DISP  = 5'd2;
  localparam pc_t P_Q0    = 5'd3;
  localparam pc_t P_QT    = 5'd4;
  localparam pc_t P_QJ    = 5'd5;
  localparam pc_t P_QK    = 5'd6;
  localparam pc_t P_QR    = 5'd7;
  localparam pc_t P_QA    = 5'd8;
  localparam pc_t P_QSJ   = 5'd9;
  localparam pc_t P_QSI   = 5'd10;
  localparam pc_t P_QN    = 5'd11;
  localparam pc_t P_EMIT  = 5'd12;
  localparam pc_t P_QEND  = 5'd13;
  localparam pc_t P_A0    = 5'd14;
  localparam pc_t P_AI    = 5'd15;
  localparam pc_t P_AJ    = 5'd16;
  localparam pc_t P_AK    = 5'd17;
  localparam pc_t P_AR    = 5'd18;
  localparam pc_t P_AW    = 5'd19;
  localparam pc_t P_ASJ   = 5'd20;
  localparam pc_t P_ASI   = 5'd21;
  localparam pc_t P_AEND  = 5'd22;

  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t c;
    c = '0;
    c.cond = C_NEVER;
    c.target = P_IDLE;
    case (pc)
      P_CLR: begin
        c.clr = 1'b1; c.cond = C_CLR_MORE; c.target = P_CLR;
      end
      P_IDLE: begin
        c.rdy = 1'b1; c.cond = C_NO_REQ; c.target = P_IDLE;
      end
      P_DISP: begin
        c.cond = C_IS_ADD; c.target = P_A0;
      end
      P_Q0: begin
        c.clr_acc = 1'b1; c.term_rst = 1'b1; c.cond = C_EMPTY; c.target = P_EMIT;
      end
      P_QT: begin
        c.ld_i = 1'b1; c.cond = C_TERM_SKIP; c.target = P_QN;
      end
      P_QJ: c.ld_j = 1'b1;
      P_QK: c.ld_k = 1'b1;
      P_QR: c.rd = 1'b1;
      P_QA: begin
        c.acc = 1'b1; c.step_k = 1'b1; c.cond = C_K_MORE; c.target = P_QR;
      end
      P_QSJ: begin
        c.step_j = 1'b1; c.cond = C_J_MORE; c.target = P_QK;
      end
      P_QSI: begin
        c.step_i = 1'b1; c.cond = C_I_MORE; c.target = P_QJ;
      end
      P_QN: begin
        c.next_term = 1'b1; c.cond = C_TERM_MORE; c.target = P_QT;
      end
      P_EMIT: begin
        c.emit = 1'b1; c.cond = C_OUT_FULL; c.target = P_EMIT;
      end
      P_QEND: begin
        c.cond = C_ALWAYS; c.target = P_IDLE;
      end
      P_A0: begin
        c.cond = C_OUT_RANGE; c.target = P_IDLE;
      end
      P_AI: c.ld_i = 1'b1;
      P_AJ: c.ld_j = 1'b1;
      P_AK: c.ld_k = 1'b1;
      P_AR: c.rd = 1'b1;
      P_AW: begin
        c.wr = 1'b1; c.step_k = 1'b1; c.cond = C_K_MORE; c.target = P_AR;
      end
      P_ASJ: begin
        c.step_j = 1'b1; c.cond = C_J_MORE; c.target = P_AK;
      end
      P_ASI: begin
        c.step_i = 1'b1; c.cond = C_I_MORE; c.target = P_AJ;
      end
      P_AEND: begin
        c.cond = C_ALWAYS; c.target = P_IDLE;
      end
      default: begin
        c.cond = C_ALWAYS; c.target = P_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

>>> rtl/bsf3_useq.sv
// ----------------------------------------------------------------------------
// bsf3_useq
// Step counter and control store: one control word per step, with a
// conditional jump selected by the word's condition field.
// ----------------------------------------------------------------------------
module bsf3_useq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bsf3_pkg::flags_t flags_i,
  output bsf3_pkg::ctrl_t  ctrl_o
);
  import bsf3_pkg::*;

  pc_t   pc_q, pc_d;
  ctrl_t cw;
  logic  take;

  always_comb begin
    cw = ucode(pc_q);
    case (cw.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_REQ:    take = ~flags_i.req;
      C_IS_ADD:    take = flags_i.is_add;
      C_EMPTY:     take = flags_i.empty;
      C_TERM_SKIP: take = flags_i.term_skip;
      C_K_MORE:    take = flags_i.k_more;
      C_J_MORE:    take = flags_i.j_more;
      C_I_MORE:    take = flags_i.i_more;
      C_TERM_MORE: take = flags_i.term_more;
      C_OUT_FULL:  take = flags_i.out_full;
      C_OUT_RANGE: take = flags_i.out_range;
      C_CLR_MORE:  take = flags_i.clr_more;
      default:     take = 1'b0;
    endcase
    pc_d = take ? cw.target : pc_t'(pc_q + 5'd1);
  end

  assign ctrl_o = cw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= P_CLR;
    end else begin
      pc_q <= pc_d;
    end
  end

  // the clearing pass runs once, right after reset
  a_clr_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q != P_CLR) |=> (pc_q != P_CLR))
    else $error("sequencer returned to the clearing pass");

  // an idle step without a request holds
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == P_IDLE && !flags_i.req) |=> (pc_q == P_IDLE))
    else $error("idle step left without a request");

  // a read is always followed by its use
  a_rd_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cw.rd |=> (ctrl_o.acc || ctrl_o.wr))
    else $error("tree read not consumed in the next step");

endmodule

>>> rtl/box_sum_fenwick_3d_core.sv
// ----------------------------------------------------------------------------
// box_sum_fenwick_3d_core
// Three-dimensional binary indexed tree with point add and box-sum query.
// ----------------------------------------------------------------------------
// After reset the tree memory is cleared one word per cycle, all 2^(3*ceil(log2
// SIZE_PER_AXIS)) words (4096 at size 16), with in_ready_o low. Items are
// then handled one at a time by a microcoded sequencer over a single-port
// tree memory with registered read data; every tree cell visited takes a
// read step, then an accumulate or write-back step. An add touches Lx*Ly*Lz
// cells (L = length of the i|(i+1) chain per axis). A query walks eight
// prefix sums of Lx*Ly*Lz cells each (L = length of the (i&(i+1))-1 chain
// per axis), or none when a prefix starts at -1; at size 16 that is at most
// 343 cells. An empty box visits no cells. A result sits in an output
// register, so the next request is taken while it waits.
module box_sum_fenwick_3d_core #(
  parameter int unsigned SIZE_PER_AXIS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic        [3:0]  pos_x_i,
  input  logic        [3:0]  pos_y_i,
  input  logic        [3:0]  pos_z_i,
  input  logic        [4:0]  end_x_i,
  input  logic        [4:0]  end_y_i,
  input  logic        [4:0]  end_z_i,
  input  logic signed [31:0] amount_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] box_sum_o
);
  import bsf3_pkg::*;

  localparam int unsigned CW = (SIZE_PER_AXIS > 1) ? $clog2(SIZE_PER_AXIS) : 1;
  localparam int unsigned AW = 3 * CW;

  ctrl_t  ctrl;
  flags_t flags;

  logic        kind_q;
  logic [3:0]  pos_x_q, pos_y_q, pos_z_q;
  logic [4:0]  end_x_q, end_y_q, end_z_q;
  logic [31:0] amount_q;

  logic [CW-1:0] i_q, j_q, k_q;
  logic [2:0]    term_q;
  logic [31:0]   acc_q;
  logic [31:0]   rdata_q;
  logic [AW-1:0] clr_cnt_q;
  logic          out_valid_q, out_valid_d;
  logic [31:0]   box_sum_q;

  logic [31:0] mem_q [2**AW];

  logic          req_take;
  logic [31:0]   ex_c, ey_c, ez_c;
  logic [CW-1:0] hi_x, hi_y, hi_z, lo_x, lo_y, lo_z;
  logic [CW-1:0] st_x, st_y, st_z;
  logic [AW-1:0] cell_addr, mem_waddr;
  logic [31:0]   mem_wdata;
  logic          mem_we;
  logic          out_full;

  // zero-based tree walks: up for an add, down for a prefix sum
  function automatic logic [CW-1:0] axis_next(input logic [CW-1:0] v, input logic qry);
    logic [CW:0]   up;
    logic [CW-1:0] dn;
    up = {1'b0, v} | ({1'b0, v} + 1'b1);
    dn = v & (v + 1'b1);
    return qry ? (dn - 1'b1) : up[CW-1:0];
  endfunction

  function automatic logic axis_more(input logic [CW-1:0] v, input logic qry);
    logic [CW:0]   up;
    logic [CW-1:0] dn;
    up = {1'b0, v} | ({1'b0, v} + 1'b1);
    dn = v & (v + 1'b1);
    return qry ? (dn != '0) : (32'(up) < SIZE_PER_AXIS);
  endfunction

  bsf3_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  assign in_ready_o = ctrl.rdy;
  assign req_take   = in_valid_i & ctrl.rdy;

  always_ff @(posedge clk_i) begin
    if (req_take) begin
      kind_q   <= kind_i;
      pos_x_q  <= pos_x_i;
      pos_y_q  <= pos_y_i;
      pos_z_q  <= pos_z_i;
      end_x_q  <= end_x_i;
      end_y_q  <= end_y_i;
      end_z_q  <= end_z_i;
      amount_q <= amount_i;
    end
  end

  // clamp the query end to the cube, then form the prefix corners
  always_comb begin
    ex_c = (32'(end_x_q) > SIZE_PER_AXIS) ? SIZE_PER_AXIS : 32'(end_x_q);
    ey_c = (32'(end_y_q) > SIZE_PER_AXIS) ? SIZE_PER_AXIS : 32'(end_y_q);
    ez_c = (32'(end_z_q) > SIZE_PER_AXIS) ? SIZE_PER_AXIS : 32'(end_z_q);
    hi_x = CW'(ex_c - 32'd1);
    hi_y = CW'(ey_c - 32'd1);
    hi_z = CW'(ez_c - 32'd1);
    lo_x = CW'(32'(pos_x_q) - 32'd1);
    lo_y = CW'(32'(pos_y_q) - 32'd1);
    lo_z = CW'(32'(pos_z_q) - 32'd1);
    // term bit set picks the low corner on that axis
    st_x = kind_q ? (term_q[2] ? lo_x : hi_x) : CW'(32'(pos_x_q));
    st_y = kind_q ? (term_q[1] ? lo_y : hi_y) : CW'(32'(pos_y_q));
    st_z = kind_q ? (term_q[0] ? lo_z : hi_z) : CW'(32'(pos_z_q));
  end

  always_comb begin
    out_full        = out_valid_q & ~out_ready_i;
    flags.req       = in_valid_i;
    flags.is_add    = ~kind_q;
    flags.empty     = (ex_c <= 32'(pos_x_q)) || (ey_c <= 32'(pos_y_q))
                      || (ez_c <= 32'(pos_z_q));
    // a prefix at index -1 is zero
    flags.term_skip = (term_q[2] && pos_x_q == 4'd0) || (term_q[1] && pos_y_q == 4'd0)
                      || (term_q[0] && pos_z_q == 4'd0);
    flags.k_more    = axis_more(k_q, kind_q);
    flags.j_more    = axis_more(j_q, kind_q);
    flags.i_more    = axis_more(i_q, kind_q);
    flags.term_more = (term_q != 3'd7);
    flags.out_full  = out_full;
    flags.out_range = (32'(pos_x_q) >= SIZE_PER_AXIS) || (32'(pos_y_q) >= SIZE_PER_AXIS)
                      || (32'(pos_z_q) >= SIZE_PER_AXIS);
    flags.clr_more  = (clr_cnt_q != '1);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.ld_i) begin
      i_q <= st_x;
    end else if (ctrl.step_i) begin
      i_q <= axis_next(i_q, kind_q);
    end
    if (ctrl.ld_j) begin
      j_q <= st_y;
    end else if (ctrl.step_j) begin
      j_q <= axis_next(j_q, kind_q);
    end
    if (ctrl.ld_k) begin
      k_q <= st_z;
    end else if (ctrl.step_k) begin
      k_q <= axis_next(k_q, kind_q);
    end
    if (ctrl.term_rst) begin
      term_q <= 3'd0;
    end else if (ctrl.next_term) begin
      term_q <= term_q + 3'd1;
    end
    // odd number of low corners subtracts
    if (ctrl.clr_acc) begin
      acc_q <= '0;
    end else if (ctrl.acc) begin
      acc_q <= (^term_q) ? (acc_q - rdata_q) : (acc_q + rdata_q);
    end
  end

  // tree memory
  assign cell_addr = {i_q, j_q, k_q};
  assign mem_we    = ctrl.clr | ctrl.wr;
  assign mem_waddr = ctrl.clr ? clr_cnt_q : cell_addr;
  assign mem_wdata = ctrl.clr ? 32'd0 : (rdata_q + amount_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (ctrl.rd) begin
      rdata_q <= mem_q[cell_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (ctrl.clr) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.emit && !out_full) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit && !out_full) begin
      box_sum_q <= acc_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign box_sum_o   = box_sum_q;

  // tree reads stay inside the cube
  a_rd_in_cube: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.rd |-> (32'(i_q) < SIZE_PER_AXIS && 32'(j_q) < SIZE_PER_AXIS
                 && 32'(k_q) < SIZE_PER_AXIS))
    else $error("tree access outside the cube");

  // a result only appears from an emit step, carrying the sum
  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(ctrl.emit) && box_sum_q == $past(acc_q)))
    else $error("result raised without emit");

  // no request is taken during the clearing pass or while a request is in work
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.clr || ctrl.rd || ctrl.wr || ctrl.acc) |-> !in_ready_o)
    else $error("request taken while busy");

endmodule
